// File: hdl/qnlerp_pkg.sv
// Shared types and constants for the quaternion blend pipeline.
package qnlerp_pkg;

    localparam logic [31:0] ONE_Q30    = 32'd1073741824;
    localparam logic [31:0] TWO_Q30    = 32'd2147483648;
    localparam logic [31:0] THREE_Q30  = 32'd3221225472;
    localparam logic [31:0] SEG1_SLOPE = 32'd314491699;
    localparam logic [31:0] SEG2_BASE  = 32'd759250125;
    localparam logic [31:0] SEG2_SLOPE = 32'd111189606;
    localparam logic [15:0] BLEND_ONE  = 16'd32768;

    // Per-item sideband carried down the pipeline
    typedef struct packed {
        logic       zero;
        logic [5:0] shift;
        logic       hneg;
    } qn_ctl_t;

endpackage

// File: hdl/qnlerp_lane.sv
// One component lane: blend and square.
module qnlerp_lane
    import qnlerp_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [15:0] a,
    input  logic signed [15:0] b,
    input  logic               neg,
    input  logic [15:0]        t,
    output logic signed [31:0] m,
    output logic [61:0]        sq
);
    logic signed [17:0] av;
    logic signed [18:0] d;
    logic signed [35:0] prod;
    logic signed [31:0] m_reg;
    logic signed [31:0] m_next;
    logic [61:0]        sq_reg;

    // Form the blended component a*1.0 + (b-a)*t, with a negated when neg is set
    always_comb
    begin
        av     = neg ? -18'(a) : 18'(a);
        d      = 19'(b) - 19'(av);
        prod   = 36'(d) * $signed({20'd0, t});
        m_next = 32'(36'(av) * 36'sd32768 + prod);
    end

    // Register the blend, then its square
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg  <= m_next;
            sq_reg <= 62'(m_reg * m_reg);
        end
    end

    assign m  = m_reg;
    assign sq = sq_reg;
endmodule

// File: hdl/qnlerp_rsqrt.sv
// Pipelined reciprocal square root: chord guess then Newton steps.
module qnlerp_rsqrt
    import qnlerp_pkg::*;
#(
    parameter int ITER = 3
)
(
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] u30,
    output logic [31:0] y
);
    localparam int NS = 1 + 3 * ITER;
    logic [31:0] u_reg [NS];
    logic [31:0] y_reg [NS];
    logic [31:0] q_reg [NS];
    logic [31:0] p_reg [NS];
    logic [63:0] g;

    always_comb
    begin
        if (u30 < TWO_Q30)
            g = 64'(ONE_Q30) - ((64'(SEG1_SLOPE) * 64'(u30 - ONE_Q30)) >> 30);
        else
            g = 64'(SEG2_BASE) - ((64'(SEG2_SLOPE) * 64'(u30 - TWO_Q30)) >> 30);
    end

    // Advance guess, then q, p and update per iteration
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg[0] <= u30;
            y_reg[0] <= 32'(g);
            q_reg[0] <= '0;
            p_reg[0] <= '0;
            for (int k = 0; k < ITER; k++)
            begin
                u_reg[3*k+1] <= u_reg[3*k];
                y_reg[3*k+1] <= y_reg[3*k];
                q_reg[3*k+1] <= 32'((64'(y_reg[3*k]) * 64'(y_reg[3*k])) >> 30);
                p_reg[3*k+1] <= '0;
                u_reg[3*k+2] <= u_reg[3*k+1];
                y_reg[3*k+2] <= y_reg[3*k+1];
                q_reg[3*k+2] <= q_reg[3*k+1];
                p_reg[3*k+2] <= 32'((64'(u_reg[3*k+1]) * 64'(q_reg[3*k+1])) >> 30);
                u_reg[3*k+3] <= u_reg[3*k+2];
                y_reg[3*k+3] <= 32'((64'(y_reg[3*k+2]) *
                    ((p_reg[3*k+2] >= THREE_Q30) ? 64'd0 :
                     64'(THREE_Q30 - p_reg[3*k+2]))) >> 31);
                q_reg[3*k+3] <= '0;
                p_reg[3*k+3] <= '0;
            end
        end
    end

    assign y = y_reg[NS-1];
endmodule

// File: hdl/quaternion_nlerp_core.sv
// Top level of the shortest-path normalized quaternion blend.
// Usage: s_axis carries two quaternions and a blend factor per item; one
// result item leaves on m_axis per input item, in order.
// Throughput: one item per cycle while m_axis does not stall. The stages are
// the input register, blend and square in the four lanes, square sum,
// normalise shift, the 1 + 3*RSQRT_ITERATIONS reciprocal square root
// stages, and the scaling stage.
// The pipeline advances only when its output register is empty or being
// taken, so a stall on m_axis freezes every stage and s_axis_tready drops.
// Reset clears all valid flags; payload registers are not reset.
// s_axis_tdata bits, low to high: first_x, first_y, first_z, first_w,
// second_x, second_y, second_z, second_w, blend.
// m_axis_tdata bits, low to high: out_x, out_y, out_z, out_w, zero_length,
// then seven zero bits.
// The zero_length flag is set, with all components zero, when the blend
// has no length.
module quaternion_nlerp_core
    import qnlerp_pkg::*;
#(
    parameter int COMPONENT_FRACTION_BITS = 14,
    parameter int RSQRT_ITERATIONS = 3
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [143:0] s_axis_tdata,  // first_x..w, second_x..w, blend
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata   // out_x..w, zero_length, pad
);
    localparam int F  = COMPONENT_FRACTION_BITS;
    localparam int RS = 1 + 3 * RSQRT_ITERATIONS;
    localparam int OS = RS + 2;
    localparam int LAT = 5 + RS + 1;
    localparam logic [15:0] LIMIT = (F >= 15) ? 16'd32767 : 16'(1 << F);

    logic en;
    logic [LAT-1:0] vld_reg;
    logic signed [15:0] a [4];
    logic signed [15:0] b [4];
    logic [15:0] t;
    logic signed [31:0] pr [4];
    logic signed [33:0] dot;
    logic signed [31:0] m [4];
    logic [61:0] sq [4];

    // Stage 0 registers: inputs and dot product pieces
    logic signed [15:0] a_reg [4];
    logic signed [15:0] b_reg [4];
    logic [15:0]        t_reg;
    logic signed [31:0] pr_reg [4];
    logic [63:0]        s_reg;
    logic [63:0]        u_reg;
    logic [5:0]         p;
    logic [31:0]        y;
    logic signed [31:0] mq_reg [OS+1][4];
    qn_ctl_t            ctl_reg [2:OS];
    logic [15:0]        o_reg [4];
    logic               oz_reg;

    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            a[i]  = s_axis_tdata[16*i +: 16];
            b[i]  = s_axis_tdata[64 + 16*i +: 16];
            pr[i] = 32'(a[i] * b[i]);
        end
        t = (s_axis_tdata[143:128] > BLEND_ONE) ? BLEND_ONE : s_axis_tdata[143:128];
        dot = 34'(pr_reg[0]) + 34'(pr_reg[1]) + 34'(pr_reg[2]) + 34'(pr_reg[3]);
    end

    // Valid pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
    end

    // Capture operands and products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg  <= a;
            b_reg  <= b;
            t_reg  <= t;
            pr_reg <= pr;
        end
    end

    // Lanes: stage 1 takes the sign from the dot product
    for (genvar i = 0; i < 4; i++)
    begin : g_lane
        qnlerp_lane u_lane (
            .clk (clk), .en (en), .a (a_reg[i]), .b (b_reg[i]),
            .neg (dot[33]), .t (t_reg), .m (m[i]), .sq (sq[i])
        );
    end

    // Leading-one search over the sum
    always_comb
    begin
        p = 6'd0;
        for (int k = 0; k < 64; k++)
            if (s_reg[k])
                p = 6'(k);
    end

    // Merge: sum of squares, normalise shift, and delay the blend values
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg <= 64'(sq[0]) + 64'(sq[1]) + 64'(sq[2]) + 64'(sq[3]);
            for (int i = 0; i < 4; i++)
            begin
                mq_reg[0][i] <= m[i];
                mq_reg[1][i] <= mq_reg[0][i];
            end
            if (p >= 6'd62)
                u_reg <= s_reg >> 2;
            else
                u_reg <= s_reg << (6'd61 - p) / 2 * 2;
            ctl_reg[2] <= '{zero: (s_reg == 64'd0),
                            shift: (p >= 6'd62) ? 6'd0 : ((6'd61 - p) >> 1),
                            hneg: (p >= 6'd62)};
            for (int i = 0; i < 4; i++)
                mq_reg[2][i] <= mq_reg[1][i];
            for (int k = 3; k <= OS; k++)
            begin
                ctl_reg[k] <= ctl_reg[k-1];
                mq_reg[k]  <= mq_reg[k-1];
            end
        end
    end

    qnlerp_rsqrt #(.ITER(RSQRT_ITERATIONS)) u_rsqrt (
        .clk (clk), .en (en), .u30 (u_reg[61:30]), .y (y)
    );

    // Scale, round half away from zero, saturate
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            oz_reg <= ctl_reg[OS].zero;
            for (int i = 0; i < 4; i++)
            begin
                logic signed [31:0] mv;
                logic [31:0] mag;
                logic [63:0] v;
                int r;
                mv  = mq_reg[OS][i];
                mag = mv[31] ? 32'(-mv) : 32'(mv);
                v   = 64'(mag) * 64'(y);
                r   = ctl_reg[OS].hneg ? 61 - F :
                      60 - int'(ctl_reg[OS].shift) - F;
                if (r < 0)
                    r = 0;
                if (r > 0)
                    v = (v + (64'd1 << (r - 1))) >> r;
                if (v > 64'(LIMIT))
                    v = 64'(LIMIT);
                if (ctl_reg[OS].zero)
                    o_reg[i] <= '0;
                else
                    o_reg[i] <= mv[31] ? 16'(-v) : 16'(v);
            end
        end
    end

    assign m_axis_tvalid = vld_reg[LAT-1];
    assign m_axis_tdata  = {7'd0, oz_reg, o_reg[3], o_reg[2], o_reg[1], o_reg[0]};
endmodule

// File: verif/tb_quaternion_nlerp_core.sv
// Self-checking testbench for the shortest-path quaternion blend core.
module tb_quaternion_nlerp_core
    import qnlerp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS = 14;
    localparam int NEWTON_STEPS = 3;
    localparam int PIPE_DEPTH = 7 + 3 * NEWTON_STEPS;

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } quat_t;

    typedef struct packed {
        logic        zero_length;
        quat_t       q;
    } blend_res_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata;   // first_x..w, second_x..w, blend
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [71:0]  m_axis_tdata;   // out_x..w, zero_length, pad

    blend_res_t   expected_blends[$];
    int           mismatches;
    bit           sending_done;

    quaternion_nlerp_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Free-running clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Reciprocal square root in Q30: chord seed then Newton steps
    function automatic logic [63:0] rsqrt_q30(input logic [63:0] u30);
        logic [63:0] y;
        logic [63:0] q;
        logic [63:0] p;
        logic [63:0] f;
        if (u30 < 64'(TWO_Q30))
            y = 64'(ONE_Q30) - ((64'(SEG1_SLOPE) * (u30 - 64'(ONE_Q30))) >> 30);
        else
            y = 64'(SEG2_BASE) - ((64'(SEG2_SLOPE) * (u30 - 64'(TWO_Q30))) >> 30);
        for (int i = 0; i < NEWTON_STEPS; i++)
        begin
            q = (y * y) >> 30;
            p = (u30 * q) >> 30;
            f = (p >= 64'(THREE_Q30)) ? 64'd0 : (64'(THREE_Q30) - p);
            y = (y * f) >> 31;
        end
        return y;
    endfunction

    // Blend, normalise and saturate one item
    function automatic blend_res_t predict_blend(input quat_t a, input quat_t b,
                                                 input logic [15:0] t_raw);
        longint     av[4];
        longint     bv[4];
        longint     m[4];
        longint     dot;
        longint     t;
        logic [63:0] s;
        logic [63:0] u;
        logic [63:0] y;
        logic [63:0] mag;
        logic [63:0] v;
        logic [63:0] limit;
        int         p;
        int         h;
        int         r;
        logic [15:0] comp[4];
        blend_res_t res;
        av[0] = a.x; av[1] = a.y; av[2] = a.z; av[3] = a.w;
        bv[0] = b.x; bv[1] = b.y; bv[2] = b.z; bv[3] = b.w;
        dot = 0;
        for (int i = 0; i < 4; i++)
            dot += av[i] * bv[i];
        t = (t_raw > BLEND_ONE) ? longint'(BLEND_ONE) : longint'(t_raw);
        s = 0;
        for (int i = 0; i < 4; i++)
        begin
            if (dot < 0)
                av[i] = -av[i];
            m[i] = av[i] * 32768 + (bv[i] - av[i]) * t;
            s += 64'(m[i] * m[i]);
        end
        res = '0;
        if (s == 0)
        begin
            res.zero_length = 1'b1;
            return res;
        end
        p = 63;
        while (p > 0 && s[p] == 1'b0)
            p--;
        if (p >= 62)
        begin
            h = -1;
            u = s >> 2;
        end
        else
        begin
            h = (61 - p) >> 1;
            u = s << (2 * h);
        end
        y = rsqrt_q30(u >> 30);
        limit = (FRAC_BITS >= 15) ? 64'd32767 : (64'd1 << FRAC_BITS);
        r = 60 - h - FRAC_BITS;
        if (r < 0)
            r = 0;
        for (int i = 0; i < 4; i++)
        begin
            mag = (m[i] < 0) ? 64'(-m[i]) : 64'(m[i]);
            v = mag * y;
            if (r > 0)
                v = (v + (64'd1 << (r - 1))) >> r;
            if (v > limit)
                v = limit;
            comp[i] = (m[i] < 0) ? 16'(-v) : 16'(v);
        end
        res.q.x = comp[0]; res.q.y = comp[1]; res.q.z = comp[2]; res.q.w = comp[3];
        return res;
    endfunction

    // Send one item after a random gap and queue its expected result;
    // tvalid stays high when the next item follows with no gap
    task automatic send_blend(input quat_t a, input quat_t b, input logic [15:0] t,
                              input bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  <= {t, b, a};
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        expected_blends.push_back(predict_blend(a, b, t));
        @(negedge clk);
    endtask

    function automatic quat_t rand_quat(input int lim);
        quat_t q;
        q.x = 16'($signed($urandom_range(0, 2 * lim)) - lim);
        q.y = 16'($signed($urandom_range(0, 2 * lim)) - lim);
        q.z = 16'($signed($urandom_range(0, 2 * lim)) - lim);
        q.w = 16'($signed($urandom_range(0, 2 * lim)) - lim);
        return q;
    endfunction

    // Extremes, sign flip, zero dot, zero length, blend saturation
    task automatic test_directed();
        quat_t id;
        quat_t neg_id;
        quat_t ox;
        quat_t full;
        quat_t most_neg;
        id = '{w: 16384, z: 0, y: 0, x: 0};
        neg_id = '{w: -16384, z: 0, y: 0, x: 0};
        ox = '{w: 0, z: 0, y: 0, x: 16384};
        full = '{w: 16384, z: 16384, y: 16384, x: 16384};
        most_neg = '{w: -32768, z: -32768, y: -32768, x: -32768};
        send_blend(id, id, 16'd0);
        send_blend(id, id, 16'd32768);
        send_blend(id, neg_id, 16'd16384);
        send_blend(id, ox, 16'd16384);
        send_blend(id, ox, 16'd65535);
        send_blend(id, ox, 16'd40000);
        send_blend('0, '0, 16'd12345);
        send_blend(id, '0, 16'd32768);
        send_blend('0, id, 16'd0);
        send_blend(full, full, 16'd1);
        send_blend(most_neg, most_neg, 16'd32767);
        send_blend(most_neg, full, 16'd100);
        send_blend('{w: 16'h7fff, z: 16'h7fff, y: 16'h7fff, x: 16'h7fff},
                   most_neg, 16'd20000);
        send_blend('{w: 0, z: 0, y: 0, x: 1}, '{w: 0, z: 0, y: 0, x: 1}, 16'd5);
        send_blend('{w: 0, z: 0, y: 1, x: 0}, '{w: 0, z: 0, y: 0, x: 0}, 16'd32767);
        send_blend(full, '{w: -16384, z: -16384, y: 16384, x: 16384}, 16'd16384);
    endtask

    // Random blends, mostly in range, some full-width and back-to-back
    task automatic test_random(input int count);
        quat_t a;
        quat_t b;
        logic [15:0] t;
        int kind;
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 6)
            begin
                a = rand_quat(16384);
                b = rand_quat(16384);
            end
            else if (kind < 8)
            begin
                a = quat_t'({$urandom, $urandom});
                b = quat_t'({$urandom, $urandom});
            end
            else
            begin
                a = rand_quat(4);
                b = (kind == 8) ? a : rand_quat(4);
            end
            t = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
            send_blend(a, b, t, (n / 100) % 4 == 3);
        end
    endtask

    // Check each result against the oldest expectation; random stalls on the output
    initial
    begin
        blend_res_t got;
        blend_res_t want;
        int stall;
        m_axis_tready = 1'b0;
        mismatches = 0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            stall = $urandom_range(0, 12);
            if ($urandom_range(0, 3) == 0 || (($time / 10000) % 5 == 2))
                stall = 0;
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            got = blend_res_t'(m_axis_tdata[64:0]);
            if (expected_blends.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                mismatches++;
            end
            else
            begin
                want = expected_blends.pop_front();
                if (got.q.x !== want.q.x)
                    $display("%0t: out_x expected %0d got %0d", $time, want.q.x, got.q.x);
                if (got.q.y !== want.q.y)
                    $display("%0t: out_y expected %0d got %0d", $time, want.q.y, got.q.y);
                if (got.q.z !== want.q.z)
                    $display("%0t: out_z expected %0d got %0d", $time, want.q.z, got.q.z);
                if (got.q.w !== want.q.w)
                    $display("%0t: out_w expected %0d got %0d", $time, want.q.w, got.q.w);
                if (got.zero_length !== want.zero_length)
                    $display("%0t: zero_length expected %0b got %0b", $time,
                             want.zero_length, got.zero_length);
                if (got !== want)
                    mismatches++;
            end
        end
    end

    // Reset, run the tests, drain and report
    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random(1550);
        s_axis_tvalid <= 1'b0;
        while (expected_blends.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 20) @(posedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// File: files.f
hdl/qnlerp_pkg.sv
hdl/qnlerp_lane.sv
hdl/qnlerp_rsqrt.sv
hdl/quaternion_nlerp_core.sv
verif/tb_quaternion_nlerp_core.sv
